// ===== design/rmt_pkg.sv =====
// rmt_pkg: shared constants, codes and types for the recursive mutex table.
// Used by rmt_free_map and recursive_mutex_table; no dependencies.
package rmt_pkg;

	localparam int SLOTS      = 8;
	localparam int COUNT_BITS = 32;
	localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ID_W       = 32;
	localparam int OP_W       = 2;
	localparam int SLOT_W     = 3;
	localparam int KIND_W     = 2;
	localparam int STATUS_W   = 2;

	// operation codes
	localparam logic [OP_W-1:0] OP_INIT    = 2'd0;
	localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;
	localparam logic [OP_W-1:0] OP_TRYLOCK = 2'd2;
	localparam logic [OP_W-1:0] OP_UNLOCK  = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BUSY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ERR  = 2'd2;

	// mutex_kind bits
	localparam int KIND_RECURSIVE = 0;
	localparam int KIND_TIMED     = 1;

	// one slot record as stored in the slot RAM
	typedef struct packed {
		logic                  recursive;
		logic [ID_W-1:0]       owner;
		logic [COUNT_BITS-1:0] count;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// allocation map update request
	typedef struct packed {
		logic             set;
		logic             clr;
		logic [IDX_W-1:0] idx;
	} map_upd_t;

	// allocation map status
	typedef struct packed {
		logic [SLOTS-1:0] in_use;
		logic             any_free;
		logic [IDX_W-1:0] first_free;
	} map_stat_t;

endpackage

// ===== design/rmt_ram.sv =====
// rmt_ram: generic single-write, single-read synchronous RAM, registered read.
// No package dependencies.
module rmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== design/rmt_free_map.sv =====
// rmt_free_map: per-slot allocated flags and lowest-free-slot encoder.
// Depends on rmt_pkg.
module rmt_free_map import rmt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  map_upd_t  upd,
	output map_stat_t stat
);

	logic [SLOTS-1:0] in_use_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
		end else if (upd.set) begin
			in_use_q[upd.idx] <= 1'b1;
		end else if (upd.clr) begin
			in_use_q[upd.idx] <= 1'b0;
		end
	end

	// scan from the top so the lowest free slot wins
	always_comb begin
		stat.in_use     = in_use_q;
		stat.any_free   = 1'b0;
		stat.first_free = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				stat.any_free   = 1'b1;
				stat.first_free = IDX_W'(i);
			end
		end
	end

endmodule

// ===== design/recursive_mutex_table.sv =====
// recursive_mutex_table: top level of the hardware recursive mutex table.
// Depends on rmt_pkg, rmt_ram (slot records) and rmt_free_map (allocated flags).
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------
//  request  | in_valid / in_ready   | opcode, slot, requester_id, mutex_kind
//  result   | out_valid / out_ready | status, granted_slot
//
// The accept cycle issues the slot RAM read; the next cycle evaluates the
// record, writes it back and loads the result register. Requests do not
// overlap: a new one is taken only after the previous one is evaluated.
// Reset clears the allocated flags and the pipeline/result valid bits; the
// slot RAM needs no clearing since init writes every record it hands out.
// in_ready drops while a request is in evaluation or an unread result stalls.
module recursive_mutex_table import rmt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OP_W-1:0]     opcode,
	input  logic [SLOT_W-1:0]   slot,
	input  logic [ID_W-1:0]     requester_id,
	input  logic [KIND_W-1:0]   mutex_kind,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [SLOT_W-1:0]   granted_slot
);

	// request held during the evaluation cycle
	logic                pend_s1;
	logic [OP_W-1:0]     op_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic                idx_ok_s1;
	logic [ID_W-1:0]     who_s1;
	logic [KIND_W-1:0]   kind_s1;

	// result register
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]   granted_q;

	logic                accept;
	logic                rd_en;
	logic [ENTRY_W-1:0]  rd_raw;
	entry_t              cur;
	entry_t              nxt;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	map_upd_t            map_upd;
	map_stat_t           map_stat;
	logic [STATUS_W-1:0] res_status;
	logic [SLOT_W-1:0]   res_granted;

	// take a request only when nothing is in evaluation and the result slot will be free
	assign in_ready = !pend_s1 && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign rd_en    = accept;

	rmt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOTS)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (nxt),
		.rd_en   (rd_en),
		.rd_addr (IDX_W'(slot)),
		.rd_data (rd_raw)
	);

	rmt_free_map u_free_map (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (map_upd),
		.stat   (map_stat)
	);

	assign cur = entry_t'(rd_raw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= accept;
		end
	end

	// capture the request payload on accept
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= opcode;
			idx_s1    <= IDX_W'(slot);
			idx_ok_s1 <= (32'(slot) < SLOTS);
			who_s1    <= requester_id;
			kind_s1   <= mutex_kind;
		end
	end

	// evaluate the operation against the record read from the slot RAM
	always_comb begin
		nxt         = cur;
		wr_en       = 1'b0;
		wr_addr     = idx_s1;
		map_upd     = '0;
		res_status  = ST_ERR;
		res_granted = '0;
		if (pend_s1) begin
			case (op_s1)
				OP_INIT: begin
					// claim the lowest free slot with a cleared record
					if (!kind_s1[KIND_TIMED] && map_stat.any_free) begin
						nxt.recursive = kind_s1[KIND_RECURSIVE];
						nxt.owner     = '0;
						nxt.count     = '0;
						wr_en         = 1'b1;
						wr_addr       = map_stat.first_free;
						map_upd.set   = 1'b1;
						map_upd.idx   = map_stat.first_free;
						res_status    = ST_OK;
						res_granted   = SLOT_W'(map_stat.first_free);
					end
				end
				OP_DESTROY: begin
					// drop the allocated flag only; the record is rewritten on reuse
					if (idx_ok_s1) begin
						map_upd.clr = 1'b1;
						map_upd.idx = idx_s1;
						res_status  = ST_OK;
					end
				end
				OP_TRYLOCK: begin
					if (idx_ok_s1 && map_stat.in_use[idx_s1]) begin
						if (cur.count == '0) begin
							nxt.count  = COUNT_BITS'(1);
							nxt.owner  = who_s1;
							wr_en      = 1'b1;
							res_status = ST_OK;
						end else if (cur.owner != who_s1) begin
							res_status = ST_BUSY;
						end else if (!cur.recursive || (&cur.count)) begin
							res_status = ST_ERR;
						end else begin
							nxt.count  = cur.count + COUNT_BITS'(1);
							wr_en      = 1'b1;
							res_status = ST_OK;
						end
					end
				end
				OP_UNLOCK: begin
					if (idx_ok_s1 && map_stat.in_use[idx_s1] &&
					    (cur.count != '0) && (cur.owner == who_s1)) begin
						nxt.count  = cur.count - COUNT_BITS'(1);
						wr_en      = 1'b1;
						res_status = ST_OK;
					end
				end
				default: begin
					res_status = ST_ERR;
				end
			endcase
		end
	end

	// result register: load at the end of evaluation, hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pend_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_s1) begin
			status_q  <= res_status;
			granted_q <= res_granted;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign granted_slot = granted_q;

endmodule
